/* design/kca_pkg.sv */
// ----------------------------------------------------------------------------
// kca_pkg
// shared types and constants for the compensated averaging block
// ----------------------------------------------------------------------------
package kca_pkg;

	localparam logic [31:0] FP_QUIET_BIT   = 32'h0040_0000;
	localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_SUB = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_Y,
		ST_T,
		ST_D,
		ST_C,
		ST_DIV
	} kca_state_t;

	typedef enum logic [2:0] {
		D_IDLE,
		D_NORM,
		D_PREP,
		D_DIV,
		D_RND,
		D_FIN,
		D_DONE
	} kca_dstate_t;

	typedef struct packed {
		logic        start;
		logic [31:0] num;
	} kca_div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] avg;
	} kca_div_rsp_t;

endpackage

/* design/kahan_compensated_average.sv */
// ----------------------------------------------------------------------------
// kahan_compensated_average
// streaming Kahan-compensated binary32 sum with average on the last request
// ----------------------------------------------------------------------------
// Each request carries one binary32 sample. The block registers it and
// then runs four passes through a single shared binary32 adder
// (y = x - comp, t = sum + y, d = t - sum, comp = d - y); s_tready stays
// low for the four adder passes, so the block takes no new sample before
// it is through with the last one. On a request marked with s_tlast the new
// sum is handed to an iterative divider, which normalizes count and sum,
// rounds the count to binary64, runs a 56-bit restoring division at one
// quotient bit per cycle, rounds the quotient to binary64 and then to
// binary32, and hands the average over to the output register once the
// master side is free. NaN, infinite and zero sums skip the divider. Sum,
// compensation and count return to +0 / 0 when the average is loaded and
// the next sample is accepted while the average waits on the master side.
// ----------------------------------------------------------------------------
module kahan_compensated_average import kca_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] sample_bits
	input  logic        s_tlast,   // last_item
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [31:0] average_bits
);

	kca_state_t state_q, state_d;

	// accumulator state
	logic [31:0]            sum_q, comp_q;
	logic [COUNT_WIDTH-1:0] count_q, count_next;
	// per-sample working registers
	logic [31:0]            x_q, y_q, t_q, d_q;
	logic                   last_q;
	// output register
	logic                   out_valid_q;
	logic [31:0]            out_data_q;

	logic [31:0]  op_a, op_b, fres;
	logic         op_sub, load;
	kca_div_req_t dreq;
	kca_div_rsp_t drsp;

	kca_fadd u_fadd (
		.a   (op_a),
		.b   (op_b),
		.sub (op_sub),
		.res (fres)
	);

	kca_fdiv #(
		.CW (COUNT_WIDTH)
	) u_fdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.count  (count_next),
		.rsp    (drsp)
	);

	// saturating sample count
	assign count_next = (&count_q) ? count_q : (count_q + 1'b1);

	// average moves to the output register once the master side is free
	assign load = (state_q == ST_DIV) && drsp.done && (!out_valid_q || m_tready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_Y;
			ST_Y:    state_d = ST_T;
			ST_T:    state_d = ST_D;
			ST_D:    state_d = ST_C;
			ST_C:    state_d = last_q ? ST_DIV : ST_IDLE;
			ST_DIV:  if (load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// adder operand steering per pass
	always_comb begin
		s_tready  = 1'b0;
		op_a      = x_q;
		op_b      = comp_q;
		op_sub    = OP_SUB;
		dreq.start = 1'b0;
		dreq.num   = t_q;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_Y: begin
				op_a   = x_q;
				op_b   = comp_q;
				op_sub = OP_SUB;
			end
			ST_T: begin
				op_a   = sum_q;
				op_b   = y_q;
				op_sub = OP_ADD;
			end
			ST_D: begin
				op_a   = t_q;
				op_b   = sum_q;
				op_sub = OP_SUB;
			end
			ST_C: begin
				op_a       = d_q;
				op_b       = y_q;
				op_sub     = OP_SUB;
				dreq.start = last_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			comp_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_C) begin
				comp_q  <= fres;
				sum_q   <= t_q;
				count_q <= count_next;
			end
			if (load) begin
				sum_q   <= '0;
				comp_q  <= '0;
				count_q <= '0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			x_q    <= s_tdata;
			last_q <= s_tlast;
		end
		if (state_q == ST_Y) y_q <= fres;
		if (state_q == ST_T) t_q <= fres;
		if (state_q == ST_D) d_q <= fres;
		if (load) out_data_q <= drsp.avg;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef ASSERT_OFF
	a_accept_starts_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_Y))
		else $error("accepted sample did not start the adder passes");

	a_div_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (count_q != '0))
		else $error("division pending with zero count");

	a_load_clears_state: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> ((count_q == '0) && (sum_q == '0) && (comp_q == '0) && m_tvalid))
		else $error("average delivered without clearing the accumulator");
`endif

endmodule

/* design/kca_fadd.sv */
// ----------------------------------------------------------------------------
// kca_fadd
// binary32 adder/subtractor, round to nearest even, subnormals kept
// ----------------------------------------------------------------------------
module kca_fadd import kca_pkg::*; (
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic        sub,
	output logic [31:0] res
);

	always_comb begin
		logic        sa, sb_eff, sl, ss, a_nan, b_nan, a_inf, b_inf, swap, inc;
		logic [7:0]  ea, eb, el, es, el_eff, es_eff, d, expf;
		logic [22:0] fl, fs;
		logic [23:0] ml, ms;
		logic [26:0] bl27, bs27, al_s, n27;
		logic [53:0] ext;
		logic [27:0] sum28;
		logic [4:0]  lz;
		logic [7:0]  sh;
		logic [8:0]  e;
		logic [30:0] packed_v;

		sa     = a[31];
		sb_eff = b[31] ^ sub;
		ea     = a[30:23];
		eb     = b[30:23];
		a_nan  = (&ea) && (|a[22:0]);
		b_nan  = (&eb) && (|b[22:0]);
		a_inf  = (&ea) && !(|a[22:0]);
		b_inf  = (&eb) && !(|b[22:0]);
		swap   = b[30:0] > a[30:0];
		sl     = swap ? sb_eff : sa;
		ss     = swap ? sa : sb_eff;
		el     = swap ? eb : ea;
		es     = swap ? ea : eb;
		fl     = swap ? b[22:0] : a[22:0];
		fs     = swap ? a[22:0] : b[22:0];
		el_eff = (el == 8'd0) ? 8'd1 : el;
		es_eff = (es == 8'd0) ? 8'd1 : es;
		ml     = {el != 8'd0, fl};
		ms     = {es != 8'd0, fs};
		d      = el_eff - es_eff;
		bl27   = {ml, 3'b000};
		bs27   = {ms, 3'b000};
		ext    = {bs27, 27'd0} >> d;
		if (d > 8'd27) begin
			al_s = {26'd0, |ms};
		end else begin
			al_s = ext[53:27] | {26'd0, |ext[26:0]};
		end
		if (sl ^ ss) begin
			sum28 = {1'b0, bl27} - {1'b0, al_s};
		end else begin
			sum28 = {1'b0, bl27} + {1'b0, al_s};
		end
		// leading zero count, highest set bit wins
		lz = 5'd27;
		for (int i = 0; i < 27; i++) begin
			if (sum28[i]) lz = 5'(26 - i);
		end
		sh = 8'd0;
		if (sum28[27]) begin
			n27 = {sum28[27:2], sum28[1] | sum28[0]};
			e   = {1'b0, el_eff} + 9'd1;
		end else begin
			sh  = ({3'd0, lz} < (el_eff - 8'd1)) ? {3'd0, lz} : (el_eff - 8'd1);
			n27 = sum28[26:0] << sh;
			e   = {1'b0, el_eff} - {1'b0, sh};
		end
		expf     = n27[26] ? e[7:0] : 8'd0;
		inc      = n27[2] & (n27[1] | n27[0] | n27[3]);
		packed_v = {expf, n27[25:3]} + {30'd0, inc};

		if (a_nan) begin
			res = a | FP_QUIET_BIT;
		end else if (b_nan) begin
			res = b | FP_QUIET_BIT;
		end else if (a_inf && b_inf && (sa != sb_eff)) begin
			res = FP_DEFAULT_NAN;
		end else if (a_inf) begin
			res = a;
		end else if (b_inf) begin
			res = {sb_eff, b[30:0]};
		end else if (sum28 == 28'd0) begin
			res = {sl & ss, 31'd0};
		end else if (e >= 9'd255) begin
			res = {sl, 8'hFF, 23'd0};
		end else begin
			res = {sl, packed_v};
		end
	end

endmodule

/* design/kca_fdiv.sv */
// ----------------------------------------------------------------------------
// kca_fdiv
// binary32 sum over integer count: binary64 quotient, then binary32 rounding
// ----------------------------------------------------------------------------
module kca_fdiv import kca_pkg::*; #(
	parameter int CW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  kca_div_req_t  req,
	input  logic [CW-1:0] count,
	output kca_div_rsp_t  rsp
);

	localparam int CSW = $clog2(CW + 1);
	localparam int SHL = 64 - CW;

	kca_dstate_t        dstate_q, dstate_d;
	logic               sign_q;
	logic [23:0]        nsig_q;
	logic signed [11:0] nexp_q, e_q;
	logic [CW-1:0]      cnt_q;
	logic [CSW-1:0]     csh_q;
	logic [52:0]        den_q, m53_q;
	logic [53:0]        rem_q;
	logic [55:0]        quo_q;
	logic [5:0]         it_q;
	logic [31:0]        res_q;

	logic               special, norm_ok, ge, rinc, dcarry, finc, f_norm;
	logic [63:0]        c64;
	logic [53:0]        dsum, r1;
	logic [52:0]        qm;
	logic               qg, qst;
	logic [53:0]        msum;
	logic signed [11:0] qe, r_raw;
	logic [6:0]         r;
	logic [116:0]       xs;
	logic [7:0]         expf;
	logic [30:0]        fpack;

	assign special = &req.num[30:23] || (req.num[30:0] == 31'd0);
	assign norm_ok = cnt_q[CW-1] && nsig_q[23];

	// denominator rounded to 53 bits
	assign c64    = 64'(cnt_q) << SHL;
	assign rinc   = c64[10] & ((|c64[9:0]) | c64[11]);
	assign dsum   = {1'b0, c64[63:11]} + {53'd0, rinc};
	assign dcarry = dsum[53];

	assign ge = rem_q >= {1'b0, den_q};
	assign r1 = ge ? (rem_q - {1'b0, den_q}) : rem_q;

	// quotient to 53 bits
	always_comb begin
		if (quo_q[55]) begin
			qm  = quo_q[55:3];
			qg  = quo_q[2];
			qst = quo_q[1] | quo_q[0] | (|rem_q);
			qe  = e_q;
		end else begin
			qm  = quo_q[54:2];
			qg  = quo_q[1];
			qst = quo_q[0] | (|rem_q);
			qe  = e_q - 12'sd1;
		end
		msum = {1'b0, qm} + {53'd0, qg & (qst | qm[0])};
	end

	// binary64 to binary32
	always_comb begin
		f_norm = e_q >= -12'sd126;
		r_raw  = -12'sd97 - e_q;
		if (f_norm) begin
			r = 7'd29;
		end else if (r_raw > 12'sd116) begin
			r = 7'd116;
		end else begin
			r = r_raw[6:0];
		end
		xs    = {m53_q, 64'd0} >> r;
		expf  = f_norm ? 8'(e_q + 12'sd127) : 8'd0;
		finc  = xs[63] & ((|xs[62:0]) | xs[64]);
		fpack = {expf, xs[86:64]} + {30'd0, finc};
	end

	always_comb begin
		dstate_d = dstate_q;
		case (dstate_q)
			D_NORM: if (norm_ok) dstate_d = D_PREP;
			D_PREP: dstate_d = D_DIV;
			D_DIV:  if (it_q == 6'd55) dstate_d = D_RND;
			D_RND:  dstate_d = D_FIN;
			D_FIN:  dstate_d = D_DONE;
			default: dstate_d = dstate_q;
		endcase
		if (req.start) dstate_d = special ? D_DONE : D_NORM;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dstate_q <= D_IDLE;
		end else begin
			dstate_q <= dstate_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sign_q <= req.num[31];
			cnt_q  <= count;
			csh_q  <= '0;
			if (req.num[30:23] == 8'd0) begin
				nsig_q <= {1'b0, req.num[22:0]};
				nexp_q <= -12'sd126;
			end else begin
				nsig_q <= {1'b1, req.num[22:0]};
				nexp_q <= 12'($signed({4'd0, req.num[30:23]})) - 12'sd127;
			end
			if (&req.num[30:23] && (|req.num[22:0])) begin
				res_q <= req.num | FP_QUIET_BIT;
			end else begin
				res_q <= req.num;
			end
		end else begin
			case (dstate_q)
				D_NORM: begin
					if (!cnt_q[CW-1]) begin
						cnt_q <= cnt_q << 1;
						csh_q <= csh_q + 1'b1;
					end
					if (!nsig_q[23]) begin
						nsig_q <= nsig_q << 1;
						nexp_q <= nexp_q - 12'sd1;
					end
				end
				D_PREP: begin
					den_q <= dcarry ? {1'b1, 52'd0} : dsum[52:0];
					e_q   <= nexp_q - 12'(CW - 1) + 12'($signed({1'b0, csh_q}))
						- (dcarry ? 12'sd1 : 12'sd0);
					rem_q <= {1'b0, nsig_q, 29'd0};
					quo_q <= '0;
					it_q  <= '0;
				end
				D_DIV: begin
					rem_q <= r1 << 1;
					quo_q <= {quo_q[54:0], ge};
					it_q  <= it_q + 6'd1;
				end
				D_RND: begin
					m53_q <= msum[53] ? {1'b1, 52'd0} : msum[52:0];
					e_q   <= msum[53] ? (qe + 12'sd1) : qe;
				end
				D_FIN: res_q <= {sign_q, fpack};
				default: ;
			endcase
		end
	end

	assign rsp.done = (dstate_q == D_DONE);
	assign rsp.avg  = res_q;

endmodule
